// ===== hdl/vsw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsw_pkg: shared types and constants of the video stall watchdog
// Event codes, recovery codes, configuration layout and the beat formats
// that pass between the watchdog modules.
// ----------------------------------------------------------------------------
package vsw_pkg;

    // Width of the time stamps and of the sample, recovery and heartbeat ages taken from them
    localparam int TIME_BITS = 32;
    // Width of the time and position fields on the ports
    localparam int NOW_BITS  = 32;
    localparam int CFG_BITS  = 16;
    localparam int CNT_BITS  = 16;
    localparam int IDX_BITS  = 3;

    // Position jump limits (ms) and the minimum advance that counts as playing
    localparam int SEEK_BACK_MS = 250;
    localparam int SEEK_FWD_MS  = 10000;
    localparam int ADVANCE_MS   = 500;

    // Register reset values
    localparam logic [CFG_BITS-1:0] RST_SAMPLE_INTERVAL = 16'd1000;
    localparam logic [CFG_BITS-1:0] RST_STALL_LIMIT     = 16'd3500;
    localparam logic [CFG_BITS-1:0] RST_COOLDOWN        = 16'd6000;
    localparam logic [CFG_BITS-1:0] RST_STABLE_RESET    = 16'd10000;
    localparam logic [CFG_BITS-1:0] RST_HEARTBEAT       = 16'd15000;
    localparam logic [CFG_BITS-1:0] RST_FRESH_FRAME     = 16'd1200;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [NOW_BITS-1:0]  t_pos;

    // Register indexes of the configuration port
    typedef enum logic [IDX_BITS-1:0] {
        CFG_SAMPLE_INTERVAL = 3'd0,
        CFG_STALL_LIMIT     = 3'd1,
        CFG_COOLDOWN        = 3'd2,
        CFG_STABLE_RESET    = 3'd3,
        CFG_HEARTBEAT       = 3'd4,
        CFG_FRESH_FRAME     = 3'd5,
        CFG_RECREATE_OK     = 3'd6
    } t_cfg_idx;

    // Event kinds
    typedef enum logic [2:0] {
        KIND_SAMPLE   = 3'd0,
        KIND_FRAME    = 3'd1,
        KIND_RENDER   = 3'd2,
        KIND_START    = 3'd3,
        KIND_SEEK     = 3'd4,
        KIND_RECONFIG = 3'd5,
        KIND_END      = 3'd6,
        KIND_DRAINED  = 3'd7
    } t_kind;

    // Video output states
    localparam logic [1:0] OUT_NOT_CONFIGURED = 2'd0;

    typedef enum logic [1:0] {
        STAGE_HEALTHY = 2'd0,
        STAGE_RELOAD  = 2'd1,
        STAGE_REBUILT = 2'd2
    } t_stage;

    typedef enum logic [1:0] {
        CAUSE_NONE      = 2'd0,
        CAUSE_OUTPUT    = 2'd1,
        CAUSE_NO_FRAMES = 2'd2
    } t_cause;

    typedef enum logic [2:0] {
        REASON_NONE        = 3'd0,
        REASON_REP_OUTPUT  = 3'd1,
        REASON_REP_FRAMES  = 3'd2,
        REASON_RENDER      = 3'd3,
        REASON_GRAPHICS    = 3'd4,
        REASON_REBUILD_BAD = 3'd5
    } t_reason;

    // Live configuration
    typedef struct packed {
        logic [CFG_BITS-1:0] sample_interval_ms;
        logic [CFG_BITS-1:0] stall_limit_ms;
        logic [CFG_BITS-1:0] cooldown_ms;
        logic [CFG_BITS-1:0] settle_ms;
        logic [CFG_BITS-1:0] beat_period_ms;
        logic [CFG_BITS-1:0] fresh_frame_ms;
        logic                recreate_ok;
    } t_cfg;

    // One event beat
    typedef struct packed {
        t_kind      kind;
        t_pos       now_ms;
        t_pos       playback_ms;
        logic       paused;
        logic       cache_paused;
        logic [1:0] output_state;
        logic       has_video;
        logic       render_failed;
        logic       graphics_failed;
        logic       rebuild_ok;
    } t_item;

    // One result beat
    typedef struct packed {
        logic                reload_request;
        logic                rebuild_attempt;
        logic                heartbeat;
        logic                stage_cleared;
        t_cause              stall_cause;
        t_stage              rec_level;
        logic                hard_pending;
        t_reason             pending_reason;
        logic [CNT_BITS-1:0] graphics_error_count;
    } t_result;

endpackage

// ===== hdl/video_stall_watchdog_core.sv =====
`timescale 1ns / 1ps
// An accepted event beat is held in the input register, then passes through the
// decision logic into the result register.
// Throughput: one event per cycle; the input stalls only while both registers
// are full and the result side stalls.
// Reset (synchronous, active low) clears the watchdog state, restores the register
// defaults and empties both stages; no clearing pass is needed.
// ----------------------------------------------------------------------------
// video_stall_watchdog_core: video pipeline stall watchdog
// Input and result registers around the watchdog engine, with the
// configuration registers beside it.
// ----------------------------------------------------------------------------
module video_stall_watchdog_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_wr_en,
    input  logic [vsw_pkg::IDX_BITS-1:0]  i_cfg_index,
    input  logic [vsw_pkg::CFG_BITS-1:0]  i_cfg_wdata,
    // event channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [2:0]                    i_kind,
    input  logic [vsw_pkg::NOW_BITS-1:0]  i_now_ms,
    input  logic [vsw_pkg::NOW_BITS-1:0]  i_playback_ms,
    input  logic                          i_paused,
    input  logic                          i_cache_paused,
    input  logic [1:0]                    i_output_state,
    input  logic                          i_has_video,
    input  logic                          i_render_failed,
    input  logic                          i_graphics_failed,
    input  logic                          i_rebuild_ok,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_reload_request,
    output logic                          o_rebuild_attempt,
    output logic                          o_heartbeat,
    output logic                          o_stage_cleared,
    output logic [1:0]                    o_stall_cause,
    output logic [1:0]                    o_rec_level,
    output logic                          o_hard_pending,
    output logic [2:0]                    o_pending_reason,
    output logic [vsw_pkg::CNT_BITS-1:0]  o_graphics_error_count
);
    import vsw_pkg::*;

    t_cfg    cfg;
    t_result result;
    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    logic    in_accept;
    logic    fire;

    vsw_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Move the held beat on whenever the result register can take it
    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Capture the event beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.kind            <= t_kind'(i_kind);
            r_in.now_ms          <= i_now_ms;
            r_in.playback_ms     <= i_playback_ms;
            r_in.paused          <= i_paused;
            r_in.cache_paused    <= i_cache_paused;
            r_in.output_state    <= i_output_state;
            r_in.has_video       <= i_has_video;
            r_in.render_failed   <= i_render_failed;
            r_in.graphics_failed <= i_graphics_failed;
            r_in.rebuild_ok      <= i_rebuild_ok;
        end
    end

    vsw_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_fire   (fire),
        .i_item   (r_in),
        .o_result (result)
    );

    // Hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_reload_request       = r_out.reload_request;
    assign o_rebuild_attempt      = r_out.rebuild_attempt;
    assign o_heartbeat            = r_out.heartbeat;
    assign o_stage_cleared        = r_out.stage_cleared;
    assign o_stall_cause          = r_out.stall_cause;
    assign o_rec_level            = r_out.rec_level;
    assign o_hard_pending         = r_out.hard_pending;
    assign o_pending_reason       = r_out.pending_reason;
    assign o_graphics_error_count = r_out.graphics_error_count;

endmodule

// ===== hdl/vsw_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsw_cfg_regs: watchdog configuration registers
// Holds the timing thresholds and the rebuild enable, written by index.
// ----------------------------------------------------------------------------
module vsw_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [vsw_pkg::IDX_BITS-1:0]   i_cfg_index,
    input  logic [vsw_pkg::CFG_BITS-1:0]   i_cfg_wdata,
    output vsw_pkg::t_cfg                  o_cfg
);
    import vsw_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the write onto one register
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SAMPLE_INTERVAL: n_cfg.sample_interval_ms = i_cfg_wdata;
                CFG_STALL_LIMIT:     n_cfg.stall_limit_ms     = i_cfg_wdata;
                CFG_COOLDOWN:        n_cfg.cooldown_ms        = i_cfg_wdata;
                CFG_STABLE_RESET:    n_cfg.settle_ms          = i_cfg_wdata;
                CFG_HEARTBEAT:       n_cfg.beat_period_ms     = i_cfg_wdata;
                CFG_FRESH_FRAME:     n_cfg.fresh_frame_ms     = i_cfg_wdata;
                CFG_RECREATE_OK:     n_cfg.recreate_ok        = i_cfg_wdata[0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_interval_ms <= RST_SAMPLE_INTERVAL;
            r_cfg.stall_limit_ms     <= RST_STALL_LIMIT;
            r_cfg.cooldown_ms        <= RST_COOLDOWN;
            r_cfg.settle_ms          <= RST_STABLE_RESET;
            r_cfg.beat_period_ms     <= RST_HEARTBEAT;
            r_cfg.fresh_frame_ms     <= RST_FRESH_FRAME;
            r_cfg.recreate_ok        <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/vsw_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsw_engine: watchdog state and per-event decision logic
// Applies one event beat to the recovery state and forms its result.
// ----------------------------------------------------------------------------
module vsw_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  vsw_pkg::t_cfg    i_cfg,
    input  logic             i_fire,
    input  vsw_pkg::t_item   i_item,
    output vsw_pkg::t_result o_result
);
    import vsw_pkg::*;

    typedef logic signed [NOW_BITS:0] t_delta;
    typedef logic [TIME_BITS:0]       t_age_x;

    // Watchdog state
    t_stage              r_stage, n_stage;
    logic                r_pending, n_pending;
    t_reason             r_reason, n_reason;
    t_time               r_frame_time, n_frame_time;
    logic                r_frame_valid, n_frame_valid;
    t_time               r_rec_time, n_rec_time;
    logic                r_rec_valid, n_rec_valid;
    t_time               r_sample_time, n_sample_time;
    logic                r_sample_valid, n_sample_valid;
    t_pos                r_sample_pos, n_sample_pos;
    t_time               r_hb_time, n_hb_time;
    logic [CNT_BITS-1:0] r_err_cnt, n_err_cnt;
    logic                r_ctx_live, n_ctx_live;

    // Derived terms
    t_time   now;
    t_time   sample_age;
    t_time   rec_age;
    t_time   hb_age;
    t_age_x  frame_age;
    t_delta  advanced;
    logic    is_seek;
    logic    advancing;
    logic    suspect;
    logic    no_fresh;
    logic    cooldown_ok;
    logic    stable_ok;
    t_result res;

    // Ages and position delta
    always_comb begin
        now        = t_time'(i_item.now_ms);
        sample_age = now - r_sample_time;
        rec_age    = now - r_rec_time;
        hb_age     = now - r_hb_time;
        frame_age  = r_frame_valid ? {1'b0, now - r_frame_time}
                                   : t_age_x'(i_cfg.stall_limit_ms) + t_age_x'(1);
        advanced   = t_delta'({1'b0, i_item.playback_ms}) - t_delta'({1'b0, r_sample_pos});
        is_seek    = (advanced < -t_delta'(SEEK_BACK_MS)) || (advanced > t_delta'(SEEK_FWD_MS));
        advancing  = advanced >= t_delta'(ADVANCE_MS);
        suspect    = i_item.has_video && (i_item.output_state == OUT_NOT_CONFIGURED);
        no_fresh   = i_item.has_video && (frame_age > t_age_x'(i_cfg.stall_limit_ms));
        cooldown_ok = !r_rec_valid || (rec_age >= t_time'(i_cfg.cooldown_ms));
        stable_ok   = !r_rec_valid || (rec_age > t_time'(i_cfg.settle_ms));
    end

    // Next state and result of the event
    always_comb begin
        n_stage        = r_stage;
        n_pending      = r_pending;
        n_reason       = r_reason;
        n_frame_time   = r_frame_time;
        n_frame_valid  = r_frame_valid;
        n_rec_time     = r_rec_time;
        n_rec_valid    = r_rec_valid;
        n_sample_time  = r_sample_time;
        n_sample_valid = r_sample_valid;
        n_sample_pos   = r_sample_pos;
        n_hb_time      = r_hb_time;
        n_err_cnt      = r_err_cnt;
        n_ctx_live     = r_ctx_live;
        res            = '0;

        case (i_item.kind)
            KIND_SAMPLE: begin
                if (!r_sample_valid) begin
                    // first sample only records where playback is
                    n_sample_valid = 1'b1;
                    n_sample_time  = now;
                    n_sample_pos   = i_item.playback_ms;
                end else if (sample_age >= t_time'(i_cfg.sample_interval_ms)) begin
                    n_sample_time = now;
                    n_sample_pos  = i_item.playback_ms;
                    if (is_seek) begin
                        n_frame_time  = now;
                        n_frame_valid = 1'b1;
                    end else begin
                        if (advancing && (hb_age >= t_time'(i_cfg.beat_period_ms))) begin
                            res.heartbeat = 1'b1;
                            n_hb_time     = now;
                        end
                        if (!i_item.paused && !i_item.cache_paused && advancing &&
                            (suspect || no_fresh)) begin
                            if (cooldown_ok) begin
                                res.stall_cause = suspect ? CAUSE_OUTPUT : CAUSE_NO_FRAMES;
                                if (r_stage == STAGE_HEALTHY) begin
                                    // first trip: ask for a reload
                                    res.reload_request = 1'b1;
                                    n_stage       = STAGE_RELOAD;
                                    n_rec_time    = now;
                                    n_rec_valid   = 1'b1;
                                    n_frame_time  = now;
                                    n_frame_valid = 1'b1;
                                end else begin
                                    // repeat: arm the hard recovery
                                    n_pending = 1'b1;
                                    n_reason  = suspect ? REASON_REP_OUTPUT
                                                        : REASON_REP_FRAMES;
                                end
                            end
                        end else if ((r_stage != STAGE_HEALTHY) && advancing &&
                                     (frame_age < t_age_x'(i_cfg.fresh_frame_ms)) &&
                                     stable_ok) begin
                            n_stage           = STAGE_HEALTHY;
                            res.stage_cleared = 1'b1;
                        end
                    end
                end
            end
            KIND_FRAME: begin
                if (r_ctx_live) begin
                    n_frame_time  = now;
                    n_frame_valid = 1'b1;
                end
            end
            KIND_RENDER: begin
                if (r_ctx_live && (i_item.render_failed || i_item.graphics_failed)) begin
                    // saturate the error count
                    if (r_err_cnt != '1) begin
                        n_err_cnt = r_err_cnt + CNT_BITS'(1);
                    end
                    if (!r_pending) begin
                        n_pending = 1'b1;
                        n_reason  = i_item.render_failed ? REASON_RENDER : REASON_GRAPHICS;
                    end
                end
            end
            KIND_START: begin
                n_frame_time   = now;
                n_frame_valid  = 1'b1;
                n_rec_time     = '0;
                n_rec_valid    = 1'b0;
                n_sample_time  = '0;
                n_sample_valid = 1'b0;
                n_sample_pos   = '0;
                n_hb_time      = now;
                n_stage        = STAGE_HEALTHY;
                n_pending      = 1'b0;
                n_reason       = REASON_NONE;
            end
            KIND_SEEK: begin
                n_frame_time   = now;
                n_frame_valid  = 1'b1;
                n_sample_valid = 1'b0;
            end
            KIND_RECONFIG: begin
                n_frame_time  = now;
                n_frame_valid = 1'b1;
            end
            KIND_END: begin
                n_sample_valid = 1'b0;
            end
            KIND_DRAINED: begin
                if (r_pending && i_cfg.recreate_ok && cooldown_ok) begin
                    res.rebuild_attempt = 1'b1;
                    n_rec_time  = now;
                    n_rec_valid = 1'b1;
                    if (i_item.rebuild_ok) begin
                        n_ctx_live         = 1'b1;
                        n_frame_time       = now;
                        n_frame_valid      = 1'b1;
                        n_stage            = STAGE_REBUILT;
                        n_pending          = 1'b0;
                        n_reason           = REASON_NONE;
                        res.reload_request = 1'b1;
                    end else begin
                        n_ctx_live = 1'b0;
                        n_pending  = 1'b1;
                        n_reason   = REASON_REBUILD_BAD;
                    end
                end
            end
            default: begin
                n_stage = r_stage;
            end
        endcase

        res.rec_level            = n_stage;
        res.hard_pending         = n_pending;
        res.pending_reason       = n_reason;
        res.graphics_error_count = n_err_cnt;
    end

    // Commit the event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage        <= STAGE_HEALTHY;
            r_pending      <= 1'b0;
            r_reason       <= REASON_NONE;
            r_frame_time   <= '0;
            r_frame_valid  <= 1'b0;
            r_rec_time     <= '0;
            r_rec_valid    <= 1'b0;
            r_sample_time  <= '0;
            r_sample_valid <= 1'b0;
            r_sample_pos   <= '0;
            r_hb_time      <= '0;
            r_err_cnt      <= '0;
            r_ctx_live     <= 1'b1;
        end else if (i_fire) begin
            r_stage        <= n_stage;
            r_pending      <= n_pending;
            r_reason       <= n_reason;
            r_frame_time   <= n_frame_time;
            r_frame_valid  <= n_frame_valid;
            r_rec_time     <= n_rec_time;
            r_rec_valid    <= n_rec_valid;
            r_sample_time  <= n_sample_time;
            r_sample_valid <= n_sample_valid;
            r_sample_pos   <= n_sample_pos;
            r_hb_time      <= n_hb_time;
            r_err_cnt      <= n_err_cnt;
            r_ctx_live     <= n_ctx_live;
        end
    end

    assign o_result = res;

endmodule
